/* rtl/core/ilr_pkg.sv */
// shared constants, codes and command/status types of the indexed list unit
package ilr_pkg;

  localparam int DEPTH     = 256;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OP_W      = 3;
  localparam int POS_W     = 9;
  localparam int VAL_W     = 32;
  localparam int CNT_OUT_W = 9;
  localparam int ST_W      = 2;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [OP_W-1:0] OP_GET    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET    = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd3;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {RA_IN_POS, RA_IDX_DN, RA_IDX_UP} ra_sel_t;
  typedef enum logic [1:0] {WA_IN_POS, WA_COUNT, WA_IDX, WA_POS_Q} wa_sel_t;
  typedef enum logic [1:0] {WD_IN, WD_RAM, WD_VAL_Q} wd_sel_t;
  typedef enum logic [2:0] {IDX_HOLD, IDX_LOAD_CNT, IDX_LOAD_POS, IDX_INC, IDX_DEC} idx_op_t;
  typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC} cnt_op_t;
  typedef enum logic [1:0] {RES_ZERO, RES_RAM, RES_HOLD} res_sel_t;

  typedef struct packed {
    logic            take;
    logic            ram_re;
    ra_sel_t         ra_sel;
    logic            ram_we;
    wa_sel_t         wa_sel;
    wd_sel_t         wd_sel;
    idx_op_t         idx_op;
    cnt_op_t         cnt_op;
    logic            hold_load;
    logic            res_load;
    res_sel_t        res_sel;
    logic [ST_W-1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic pos_ge_cnt;
    logic pos_gt_cnt;
    logic full;
    logic ins_tail;
    logic rem_tail;
    logic ins_last;
    logic rem_last;
    logic res_free;
  } stat_t;

endpackage

/* rtl/core/ilr_if.sv */
// request and result channel interfaces of the indexed list unit
interface ilr_req_if import ilr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] write_value;

  modport source (output valid, output operation, output position, output write_value,
                  input ready);
  modport sink (input valid, input operation, input position, input write_value,
                output ready);
endinterface

interface ilr_rsp_if import ilr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [CNT_OUT_W-1:0]    entry_count;
  logic [ST_W-1:0]         status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink (input valid, input read_value, input entry_count, input status,
                output ready);
endinterface

/* rtl/core/indexed_list_insert_remove_unit.sv */
// top level of the indexed list unit with insert and remove
//
//  channel  dir  fields                                  accepted when
//  req      in   operation, position, write_value        req.valid && req.ready
//  rsp      out  read_value, entry_count, status         rsp.valid && rsp.ready
//
// one item at a time; set, append, insert at the end, unknown codes and errors
// load the result register at accept; get reads, then loads it; remove holds
// the entry at p and moves later entries down, insert moves entries from p on
// up, then writes at p; each moved entry costs a registered read, then a write.
// reset clears the count and the result valid flag; entries need no clearing.
// a new item is taken only once the result register is free or being taken.
module indexed_list_insert_remove_unit import ilr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ilr_req_if.sink   req,
  ilr_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;

  ilr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .operation (req.operation),
    .stat      (stat),
    .req_ready (req.ready),
    .cmd       (cmd)
  );

  ilr_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .position    (req.position),
    .write_value (req.write_value),
    .stat        (stat),
    .rsp         (rsp)
  );

`ifndef SYNTHESIS
  a_one_ram_access: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ram_we && cmd.ram_re))
    else $error("ram read and write in the same cycle");

  a_result_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> stat.res_free)
    else $error("result loaded over an untaken result");

  a_no_write_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> (!cmd.ram_we || (req.valid && req.ready)))
    else $error("ram write after the item finished");

  a_take_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    cmd.take |-> (req.valid && req.ready))
    else $error("request latched without an accepted item");
`endif

endmodule

/* rtl/core/ilr_ram.sv */
// generic single write port ram with one registered read port
module ilr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/core/ilr_datapath.sv */
// entry storage, live count, shift index and result register
module ilr_datapath import ilr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] write_value,
  output stat_t                   stat,
  ilr_rsp_if.source               rsp
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [ADDR_W-1:0] pos_q;
  logic [VAL_W-1:0]  val_q;
  logic [ADDR_W-1:0] idx;
  logic [VAL_W-1:0]  hold;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [ADDR_W-1:0] in_pos_a;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;
  logic [VAL_W-1:0]  rdata;
  logic [VAL_W-1:0]  res_val;
  logic              res_valid;
  logic [VAL_W-1:0]  res_data;
  logic [CNT_OUT_W-1:0] res_count;
  logic [ST_W-1:0]   res_status;

  assign pos_ext  = CMP_W'(position);
  assign cnt_ext  = CMP_W'(count);
  assign in_pos_a = pos_ext[ADDR_W-1:0];

  always_comb begin
    unique case (cmd.ra_sel)
      RA_IN_POS: raddr = in_pos_a;
      RA_IDX_DN: raddr = idx - ADDR_W'(1);
      RA_IDX_UP: raddr = idx + ADDR_W'(1);
      default:   raddr = in_pos_a;
    endcase
  end

  always_comb begin
    unique case (cmd.wa_sel)
      WA_IN_POS: waddr = in_pos_a;
      WA_COUNT:  waddr = count[ADDR_W-1:0];
      WA_IDX:    waddr = idx;
      WA_POS_Q:  waddr = pos_q;
      default:   waddr = in_pos_a;
    endcase
  end

  always_comb begin
    unique case (cmd.wd_sel)
      WD_IN:    wdata = write_value;
      WD_RAM:   wdata = rdata;
      WD_VAL_Q: wdata = val_q;
      default:  wdata = write_value;
    endcase
  end

  ilr_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.ram_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: count_next = count;
      CNT_INC:  count_next = count + CNT_W'(1);
      CNT_DEC:  count_next = count - CNT_W'(1);
      default:  count_next = count;
    endcase
  end

  always_comb begin
    unique case (cmd.res_sel)
      RES_ZERO: res_val = '0;
      RES_RAM:  res_val = rdata;
      RES_HOLD: res_val = hold;
      default:  res_val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.res_load) begin
        res_valid <= 1'b1;
      end else if (rsp.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pos_q <= in_pos_a;
      val_q <= write_value;
    end
    if (cmd.hold_load) begin
      hold <= rdata;
    end
    unique case (cmd.idx_op)
      IDX_HOLD:     idx <= idx;
      IDX_LOAD_CNT: idx <= count[ADDR_W-1:0];
      IDX_LOAD_POS: idx <= in_pos_a;
      IDX_INC:      idx <= idx + ADDR_W'(1);
      IDX_DEC:      idx <= idx - ADDR_W'(1);
      default:      idx <= idx;
    endcase
    if (cmd.res_load) begin
      res_data   <= res_val;
      res_count  <= CNT_OUT_W'(count_next);
      res_status <= cmd.res_status;
    end
  end

  assign stat.pos_ge_cnt = (pos_ext >= cnt_ext);
  assign stat.pos_gt_cnt = (pos_ext > cnt_ext);
  assign stat.full       = (count == CNT_W'(DEPTH));
  assign stat.ins_tail   = (pos_ext == cnt_ext);
  assign stat.rem_tail   = ((CNT_W'(pos_q) + CNT_W'(1)) == count);
  assign stat.ins_last   = ((idx - ADDR_W'(1)) == pos_q);
  assign stat.rem_last   = ((CNT_W'(idx) + CNT_W'(2)) == count);
  assign stat.res_free   = !res_valid || rsp.ready;

  assign rsp.valid       = res_valid;
  assign rsp.read_value  = res_data;
  assign rsp.entry_count = res_count;
  assign rsp.status      = res_status;

endmodule

/* rtl/core/ilr_ctrl.sv */
// request decode and shift sequencer of the indexed list unit
module ilr_ctrl import ilr_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  logic [OP_W-1:0] operation,
  input  stat_t           stat,
  output logic            req_ready,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GETRD  = 3'd1;
  localparam logic [2:0] S_REMRD  = 3'd2;
  localparam logic [2:0] S_SHRD   = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;
  localparam logic [2:0] S_INSFIN = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       is_remove;
  logic       is_remove_next;
  logic       accept;

  assign req_ready = (state == S_IDLE) && stat.res_free;
  assign accept    = req_valid && req_ready;

  always_comb begin
    cmd            = '0;
    cmd.ra_sel     = RA_IN_POS;
    cmd.wa_sel     = WA_IN_POS;
    cmd.wd_sel     = WD_IN;
    cmd.idx_op     = IDX_HOLD;
    cmd.cnt_op     = CNT_HOLD;
    cmd.res_sel    = RES_ZERO;
    cmd.res_status = ST_OK;
    state_next     = state;
    is_remove_next = is_remove;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (operation)
            OP_GET: begin
              if (stat.pos_ge_cnt) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_RANGE;
              end else begin
                cmd.ram_re = 1'b1;
                state_next = S_GETRD;
              end
            end
            OP_SET: begin
              cmd.res_load = 1'b1;
              if (stat.pos_ge_cnt) begin
                cmd.res_status = ST_RANGE;
              end else begin
                cmd.ram_we = 1'b1;
              end
            end
            OP_APPEND: begin
              cmd.res_load = 1'b1;
              if (stat.full) begin
                cmd.res_status = ST_FULL;
              end else begin
                cmd.ram_we = 1'b1;
                cmd.wa_sel = WA_COUNT;
                cmd.cnt_op = CNT_INC;
              end
            end
            OP_INSERT: begin
              priority if (stat.pos_gt_cnt) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_RANGE;
              end else if (stat.full) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_FULL;
              end else if (stat.ins_tail) begin
                cmd.res_load = 1'b1;
                cmd.ram_we   = 1'b1;
                cmd.wa_sel   = WA_COUNT;
                cmd.cnt_op   = CNT_INC;
              end else begin
                cmd.take       = 1'b1;
                cmd.idx_op     = IDX_LOAD_CNT;
                is_remove_next = 1'b0;
                state_next     = S_SHRD;
              end
            end
            OP_REMOVE: begin
              if (stat.pos_ge_cnt) begin
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_RANGE;
              end else begin
                cmd.take       = 1'b1;
                cmd.ram_re     = 1'b1;
                cmd.idx_op     = IDX_LOAD_POS;
                is_remove_next = 1'b1;
                state_next     = S_REMRD;
              end
            end
            default: begin
              cmd.res_load = 1'b1;
            end
          endcase
        end
      end
      S_GETRD: begin
        cmd.res_load = 1'b1;
        cmd.res_sel  = RES_RAM;
        state_next   = S_IDLE;
      end
      S_REMRD: begin
        cmd.hold_load = 1'b1;
        if (stat.rem_tail) begin
          cmd.res_load = 1'b1;
          cmd.res_sel  = RES_RAM;
          cmd.cnt_op   = CNT_DEC;
          state_next   = S_IDLE;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_SHRD: begin
        cmd.ram_re = 1'b1;
        cmd.ra_sel = is_remove ? RA_IDX_UP : RA_IDX_DN;
        state_next = S_SHWR;
      end
      S_SHWR: begin
        cmd.ram_we = 1'b1;
        cmd.wa_sel = WA_IDX;
        cmd.wd_sel = WD_RAM;
        if (is_remove) begin
          cmd.idx_op = IDX_INC;
          if (stat.rem_last) begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_HOLD;
            cmd.cnt_op   = CNT_DEC;
            state_next   = S_IDLE;
          end else begin
            state_next = S_SHRD;
          end
        end else begin
          cmd.idx_op = IDX_DEC;
          state_next = stat.ins_last ? S_INSFIN : S_SHRD;
        end
      end
      S_INSFIN: begin
        cmd.ram_we   = 1'b1;
        cmd.wa_sel   = WA_POS_Q;
        cmd.wd_sel   = WD_VAL_Q;
        cmd.cnt_op   = CNT_INC;
        cmd.res_load = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      is_remove <= 1'b0;
    end else begin
      state     <= state_next;
      is_remove <= is_remove_next;
    end
  end

endmodule
